@@ hdl/bmta_pkg.sv @@
`default_nettype none

package bmta_pkg;

    // Fixed field widths
    localparam int unsigned TICK_W = 64;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned CFG_W  = 6;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_LATER,
        ST_EMPTY,
        ST_LOWER,
        ST_SEARCH,
        ST_MATCH,
        ST_RECORD,
        ST_FINISH
    } t_state;

    // Operand pair routed to the shared comparator
    typedef enum logic [2:0] {
        CMP_TICK,
        CMP_LATER,
        CMP_EMPTY,
        CMP_LOWER,
        CMP_PORT
    } t_cmp_sel;

    // Comparator result
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

`default_nettype wire

@@ hdl/bmta_cmp.sv @@
`default_nettype none

module bmta_cmp
    import bmta_pkg::*;
(
    input  wire logic [TICK_W-1:0] i_a,
    input  wire logic [TICK_W-1:0] i_b,
    output t_cmp_res               o_res
);

    // Unsigned equality and less-than on one shared operand pair
    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

`default_nettype wire

@@ hdl/bmta_port_mem.sv @@
`default_nettype none

module bmta_port_mem
    import bmta_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned IDX_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IDX_W-1:0]  i_waddr,
    input  wire logic [PORT_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [IDX_W-1:0]  i_raddr,
    output logic      [PORT_W-1:0] o_rdata
);

    logic [PORT_W-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/barrier_min_tick_advance_unit.sv @@
`default_nettype none

// Barrier clock for conservative time synchronization.
// Command channel: an acknowledgment (i_client_port, i_client_tick,
// i_proposed_tick) is taken at a clock edge with start high and busy low.
// busy stays high until the result has been produced.
// Result channel: o_done is high for exactly one cycle with o_ack_ok,
// o_advanced and o_sync_tick; the receiver cannot stall, so the result
// is gone after that cycle. A new command may be issued in that cycle.
// Config channel: i_cfg_valid/o_cfg_ready write the expected client count;
// write it only while the block is idle.
// Sequence: a stale tick is refused after the first compare. A new port is
// compared against every port already recorded this round, then recorded;
// a search for a repeated port stops at its matching table entry. The port
// table is searched one entry at a time (registered memory read, then
// the shared comparator), and every tick compare goes through that one
// 64-bit comparator.
// Reset: clock tick and kept minimum go to zero, the port set is emptied
// (a fill count marks the valid entries, so no clearing pass is needed)
// and the expected client count returns to 1.
module barrier_min_tick_advance_unit
    import bmta_pkg::*;
#(
    parameter int unsigned MAX_CLIENTS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [PORT_W-1:0] i_client_port,
    input  wire logic [TICK_W-1:0] i_client_tick,
    input  wire logic [TICK_W-1:0] i_proposed_tick,
    output logic                   o_done,
    output logic                   o_ack_ok,
    output logic                   o_advanced,
    output logic      [TICK_W-1:0] o_sync_tick,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_CLIENTS + 1);
    localparam int unsigned IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int unsigned EFF_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_expected;
    logic [TICK_W-1:0] r_cur, n_cur;
    logic [TICK_W-1:0] r_pend, n_pend;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [PORT_W-1:0] r_port, n_port;
    logic [TICK_W-1:0] r_ctick, n_ctick;
    logic [TICK_W-1:0] r_prop, n_prop;
    logic              r_later, n_later;
    logic              r_empty, n_empty;
    logic              r_done, n_done;
    logic              r_ok, n_ok;
    logic              r_adv, n_adv;
    logic [TICK_W-1:0] r_otick, n_otick;

    t_cmp_sel          cmp_sel;
    logic [TICK_W-1:0] cmp_a, cmp_b;
    t_cmp_res          cmp_res;

    logic              mem_we, mem_re;
    logic [PORT_W-1:0] mem_rdata;

    logic [EFF_W-1:0]  cfg_ext;
    logic [EFF_W-1:0]  eff_count;
    logic              round_full;

    // Shared comparator
    bmta_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    // Port table, valid below r_count
    bmta_port_mem #(
        .DEPTH (MAX_CLIENTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_port),
        .i_re    (mem_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // Route operands to the comparator
    always_comb begin
        case (cmp_sel)
            CMP_TICK: begin
                cmp_a = r_ctick;
                cmp_b = r_cur;
            end
            CMP_LATER: begin
                cmp_a = r_cur;
                cmp_b = r_prop;
            end
            CMP_EMPTY: begin
                cmp_a = r_pend;
                cmp_b = r_cur;
            end
            CMP_LOWER: begin
                cmp_a = r_prop;
                cmp_b = r_pend;
            end
            CMP_PORT: begin
                cmp_a = TICK_W'(mem_rdata);
                cmp_b = TICK_W'(r_port);
            end
            default: begin
                cmp_a = r_ctick;
                cmp_b = r_cur;
            end
        endcase
    end

    // Clamp the client count to 1..MAX_CLIENTS
    always_comb begin
        cfg_ext = EFF_W'(r_expected);
        if (cfg_ext == '0) begin
            eff_count = EFF_W'(1);
        end else if (cfg_ext > EFF_W'(MAX_CLIENTS)) begin
            eff_count = EFF_W'(MAX_CLIENTS);
        end else begin
            eff_count = cfg_ext;
        end
        round_full = (EFF_W'(r_count) >= eff_count);
    end

    // Next state and datapath control
    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_pend  = r_pend;
        n_count = r_count;
        n_idx   = r_idx;
        n_port  = r_port;
        n_ctick = r_ctick;
        n_prop  = r_prop;
        n_later = r_later;
        n_empty = r_empty;
        n_done  = 1'b0;
        n_ok    = r_ok;
        n_adv   = r_adv;
        n_otick = r_otick;
        cmp_sel = CMP_TICK;
        mem_we  = 1'b0;
        mem_re  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                // take a command
                if (start) begin
                    n_port  = i_client_port;
                    n_ctick = i_client_tick;
                    n_prop  = i_proposed_tick;
                    n_state = ST_TICK;
                end
            end
            ST_TICK: begin
                // refuse a stale tick
                cmp_sel = CMP_TICK;
                if (cmp_res.eq) begin
                    n_state = ST_LATER;
                end else begin
                    n_done  = 1'b1;
                    n_ok    = 1'b0;
                    n_adv   = 1'b0;
                    n_otick = r_cur;
                    n_state = ST_IDLE;
                end
            end
            ST_LATER: begin
                cmp_sel = CMP_LATER;
                n_later = cmp_res.lt;
                n_state = ST_EMPTY;
            end
            ST_EMPTY: begin
                cmp_sel = CMP_EMPTY;
                n_empty = cmp_res.eq;
                n_state = ST_LOWER;
            end
            ST_LOWER: begin
                // keep the smallest later proposal
                cmp_sel = CMP_LOWER;
                if (r_later && (r_empty || cmp_res.lt)) begin
                    n_pend = r_prop;
                end
                n_idx   = '0;
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                // read the next recorded port, or record on a miss
                if (r_idx == r_count) begin
                    n_state = ST_RECORD;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmp_sel = CMP_PORT;
                if (cmp_res.eq) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_SEARCH;
                end
            end
            ST_RECORD: begin
                mem_we  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // close the round when enough ports answered
                n_done = 1'b1;
                n_ok   = 1'b1;
                if (round_full) begin
                    n_count = '0;
                    n_cur   = r_pend;
                    n_adv   = 1'b1;
                    n_otick = r_pend;
                end else begin
                    n_adv   = 1'b0;
                    n_otick = r_cur;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_expected <= CFG_W'(1);
            r_cur      <= '0;
            r_pend     <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_expected <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_port  <= n_port;
        r_ctick <= n_ctick;
        r_prop  <= n_prop;
        r_later <= n_later;
        r_empty <= n_empty;
        r_ok    <= n_ok;
        r_adv   <= n_adv;
        r_otick <= n_otick;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_ack_ok     = r_ok;
    assign o_advanced   = r_adv;
    assign o_sync_tick  = r_otick;

endmodule

`default_nettype wire
